### rtl/swq_pkg.sv
// swq_pkg: shared types and codes for the semaphore wait queue table
// no dependencies
package swq_pkg;

	typedef enum logic [1:0] {
		OP_BLOCK  = 2'd0,
		OP_WAKE   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_PEEK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_WALK,
		S_WALK_RD,
		S_DONE
	} state_t;

endpackage

### rtl/semaphore_wait_queue_table.sv
// semaphore_wait_queue_table: table of active semaphores with FIFO wait queues
// depends on swq_pkg
//
//  channel | signals                              | direction
//  in      | in_valid, in_stall, op, sem_key, proc_id | into block
//  out     | out_valid, out_stall, status, result_proc | out of block
//
// the key search steps one descriptor per cycle through the shared key comparator
// until a hit or the last descriptor, then passes the decide and done states; a remove
// then walks the queue one link per cycle between the decide and done states. the next
// beat is taken in the cycle after the result is loaded into the output register.
// a block of a waiting process or a remove of an idle one goes straight to the done state.
// reset clears the valid and waiting bits at once, no clearing pass. in_stall is high
// from acceptance until the result moves to the output register; the done cycle
// repeats while out_stall holds an earlier result there.
module semaphore_wait_queue_table #(
	parameter int PROCS    = 32,
	parameter int KEY_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [KEY_BITS-1:0] sem_key,
	input  logic [4:0]          proc_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [4:0]          result_proc
);
	import swq_pkg::*;

	localparam int IW = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int CW = $clog2(PROCS + 1);

	// per-entry storage
	logic [PROCS-1:0]    dvalid_q;
	logic [PROCS-1:0]    waiting_q;
	logic [KEY_BITS-1:0] dkey_q  [PROCS];
	logic [IW-1:0]       dhead_q [PROCS];
	logic [IW-1:0]       dtail_q [PROCS];
	logic [IW-1:0]       link_q  [PROCS];
	logic [KEY_BITS-1:0] wkey_q  [PROCS];

	// sequencer registers
	state_t              state_q, state_d;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]       p_q;
	logic [CW-1:0]       cnt_q;
	logic                found_q;
	logic [IW-1:0]       d_q;
	logic                free_ok_q;
	logic [IW-1:0]       free_q;
	logic [IW-1:0]       cur_q, prev_q;
	logic                have_prev_q;
	logic [1:0]          st_q;
	logic [4:0]          res_q;
	logic                ovalid_q;
	logic [1:0]          ostatus_q;
	logic [4:0]          oproc_q;

	logic [IW-1:0] ci;
	logic          hit;
	logic          pid_ok;
	logic [IW-1:0] pid_idx;
	logic          early_done;

	assign ci      = cnt_q[IW-1:0];
	// shared key comparator
	assign hit     = dvalid_q[ci] && (dkey_q[ci] == key_q);
	assign pid_ok  = ({27'd0, proc_id} < 32'(PROCS));
	assign pid_idx = IW'(proc_id);
	// beats answered without a search
	assign early_done = ((op_t'(op) == OP_REMOVE) && (!pid_ok || !waiting_q[pid_idx])) ||
		((op_t'(op) == OP_BLOCK) && (!pid_ok || waiting_q[pid_idx]));

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = ovalid_q;
	assign status      = ostatus_q;
	assign result_proc = oproc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid && !in_stall) state_d = early_done ? S_DONE : S_SEARCH;
			S_SEARCH:  if (hit || cnt_q == CW'(PROCS - 1)) state_d = S_DECIDE;
			S_DECIDE:  state_d = (op_q == OP_REMOVE && found_q) ? S_WALK : S_DONE;
			S_WALK: begin
				if (cur_q == p_q || cur_q == dtail_q[d_q] || cnt_q == CW'(PROCS - 1))
					state_d = S_DONE;
			end
			S_WALK_RD: state_d = S_WALK;
			S_DONE:    if (!ovalid_q || !out_stall) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dvalid_q  <= '0;
			waiting_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register: load a finished result, release it on an accepted beat
			if (state_q == S_DONE && (!ovalid_q || !out_stall)) begin
				ovalid_q  <= 1'b1;
				ostatus_q <= st_q;
				oproc_q   <= res_q;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q      <= op_t'(op);
						p_q       <= pid_idx;
						cnt_q     <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						res_q     <= '0;
						key_q     <= (op_t'(op) == OP_REMOVE && pid_ok) ?
							wkey_q[pid_idx] : sem_key;
						st_q      <= (op_t'(op) == OP_BLOCK && pid_ok && waiting_q[pid_idx]) ?
							ST_OK : ST_NOTFOUND;
					end
				end
				S_SEARCH: begin
					// lowest free descriptor seen so far
					if (!dvalid_q[ci] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= ci;
					end
					if (hit) begin
						found_q <= 1'b1;
						d_q     <= ci;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_DECIDE: begin
					unique case (op_q)
						OP_BLOCK: begin
							if (found_q) begin
								link_q[dtail_q[d_q]] <= p_q;
								dtail_q[d_q]         <= p_q;
								st_q <= ST_OK;
							end else if (free_ok_q) begin
								dvalid_q[free_q] <= 1'b1;
								dkey_q[free_q]   <= key_q;
								dhead_q[free_q]  <= p_q;
								dtail_q[free_q]  <= p_q;
								st_q <= ST_OK;
							end else begin
								st_q <= ST_FULL;
							end
							if (found_q || free_ok_q) begin
								link_q[p_q]    <= p_q;
								wkey_q[p_q]    <= key_q;
								waiting_q[p_q] <= 1'b1;
							end
						end
						OP_WAKE: begin
							if (found_q) begin
								waiting_q[dhead_q[d_q]] <= 1'b0;
								if (dhead_q[d_q] == dtail_q[d_q]) dvalid_q[d_q] <= 1'b0;
								else dhead_q[d_q] <= link_q[dhead_q[d_q]];
								st_q  <= ST_OK;
								res_q <= 5'(dhead_q[d_q]);
							end
						end
						OP_PEEK: begin
							if (found_q) begin
								st_q  <= ST_OK;
								res_q <= 5'(dhead_q[d_q]);
							end
						end
						OP_REMOVE: begin
							cur_q       <= dhead_q[d_q];
							have_prev_q <= 1'b0;
							cnt_q       <= '0;
						end
						default: ;
					endcase
				end
				S_WALK: begin
					// one queue link per cycle
					if (cur_q == p_q) begin
						if (cur_q == dtail_q[d_q]) begin
							if (!have_prev_q) dvalid_q[d_q] <= 1'b0;
							else dtail_q[d_q] <= prev_q;
						end
						if (!have_prev_q) dhead_q[d_q] <= link_q[cur_q];
						else link_q[prev_q] <= link_q[cur_q];
						waiting_q[p_q] <= 1'b0;
						st_q  <= ST_OK;
						res_q <= 5'(p_q);
					end else if (cur_q != dtail_q[d_q] && cnt_q != CW'(PROCS - 1)) begin
						prev_q      <= cur_q;
						have_prev_q <= 1'b1;
						cur_q       <= link_q[cur_q];
						cnt_q       <= cnt_q + 1'b1;
					end
				end
				S_WALK_RD: ;
				S_DONE: ;
				default: ;
			endcase
		end
	end

endmodule

### dv/semaphore_wait_queue_table_tb.sv
`timescale 1ns / 100ps
// semaphore_wait_queue_table_tb: self-checking bench for the semaphore wait queue table
// depends on swq_pkg and semaphore_wait_queue_table; a local predictor supplies the
// expected status and process for every beat
module semaphore_wait_queue_table_tb;
	import swq_pkg::*;

	localparam int NPROC = 32;
	localparam int KBITS = 31;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		status_t   st;
		logic [4:0] pid;
	} answer_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       op;
	logic [KBITS-1:0] sem_key;
	logic [4:0]       proc_id;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [4:0]       result_proc;

	// predictor state
	bit             tbl_valid [NPROC];
	bit [KBITS-1:0] tbl_key   [NPROC];
	int unsigned    tbl_head  [NPROC];
	int unsigned    tbl_tail  [NPROC];
	int unsigned    waiter_next [NPROC];
	bit [KBITS-1:0] waiter_key  [NPROC];
	bit             waiter_blocked [NPROC];

	answer_t pending_answers [$];
	int      mismatch_count;
	int      beats_in;
	int      beats_out;
	int      idle_cycles;
	int      rx_hold;
	bit      hold_req;
	bit      rx_random;
	bit      tx_gaps;
	bit [KBITS-1:0] key_pool [8];

	semaphore_wait_queue_table #(.PROCS(NPROC), .KEY_BITS(KBITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .sem_key(sem_key), .proc_id(proc_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_proc(result_proc)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int find_sem(bit [KBITS-1:0] k);
		for (int d = 0; d < NPROC; d++)
			if (tbl_valid[d] && tbl_key[d] == k) return d;
		return -1;
	endfunction

	function automatic int free_sem();
		for (int d = 0; d < NPROC; d++)
			if (!tbl_valid[d]) return d;
		return -1;
	endfunction

	// expected answer for one input beat, updating the predictor state
	function automatic answer_t predict_answer(op_t o, bit [KBITS-1:0] k, int unsigned p);
		answer_t a;
		int d;
		int unsigned cur, prv, nxt;
		bit has_prv;
		a.st = ST_NOTFOUND;
		a.pid = '0;
		case (o)
			OP_BLOCK: begin
				if (waiter_blocked[p]) a.st = ST_OK;
				else begin
					d = find_sem(k);
					if (d < 0) begin
						d = free_sem();
						if (d >= 0) begin
							tbl_valid[d] = 1'b1;
							tbl_key[d] = k;
							tbl_head[d] = p;
						end
					end else
						waiter_next[tbl_tail[d]] = p;
					if (d < 0) a.st = ST_FULL;
					else begin
						tbl_tail[d] = p;
						waiter_next[p] = p;
						waiter_key[p] = k;
						waiter_blocked[p] = 1'b1;
						a.st = ST_OK;
					end
				end
			end
			OP_WAKE: begin
				d = find_sem(k);
				if (d >= 0) begin
					cur = tbl_head[d];
					waiter_blocked[cur] = 1'b0;
					if (cur == tbl_tail[d]) tbl_valid[d] = 1'b0;
					else tbl_head[d] = waiter_next[cur];
					a.st = ST_OK;
					a.pid = 5'(cur);
				end
			end
			OP_REMOVE: begin
				d = waiter_blocked[p] ? find_sem(waiter_key[p]) : -1;
				if (d >= 0) begin
					cur = tbl_head[d];
					prv = 0;
					has_prv = 1'b0;
					for (int n = 0; n < NPROC; n++) begin
						if (cur == p) begin
							nxt = waiter_next[cur];
							if (cur == tbl_tail[d]) begin
								if (!has_prv) tbl_valid[d] = 1'b0;
								else tbl_tail[d] = prv;
							end
							if (!has_prv) tbl_head[d] = nxt;
							else waiter_next[prv] = nxt;
							waiter_blocked[p] = 1'b0;
							a.st = ST_OK;
							a.pid = 5'(p);
							break;
						end
						if (cur == tbl_tail[d]) break;
						prv = cur;
						has_prv = 1'b1;
						cur = waiter_next[cur];
					end
				end
			end
			default: begin
				d = find_sem(k);
				if (d >= 0) begin
					a.st = ST_OK;
					a.pid = 5'(tbl_head[d]);
				end
			end
		endcase
		return a;
	endfunction

	// send one beat, wait until accepted, then predict it
	task automatic send_beat(op_t o, bit [KBITS-1:0] k, bit [4:0] p);
		int gap;
		gap = 0;
		if (tx_gaps)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		// valid goes low between beats
		repeat (gap + 1) @(posedge clk);
		in_valid <= 1'b1;
		op <= o;
		sem_key <= k;
		proc_id <= p;
		do @(posedge clk); while (in_stall);
		pending_answers.push_back(predict_answer(o, k, 32'(p)));
		beats_in++;
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("error: unexpected result beat status=%0d proc=%0d",
						status, result_proc);
			end else begin
				exp_a = pending_answers.pop_front();
				if (status !== exp_a.st || result_proc !== exp_a.pid) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("error: beat %0d expected status=%0d proc=%0d, got status=%0d proc=%0d",
							beats_out, exp_a.st, exp_a.pid, status, result_proc);
				end
			end
		end
	end

	// receiver stall: random, or a long counted hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req) begin
			rx_hold <= 400;
			out_stall <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1'b1;
		end else if (rx_random) begin
			if ($urandom_range(0, 29) == 0) rx_hold <= $urandom_range(10, 50);
			out_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL semaphore_wait_queue_table");
			$finish;
		end
	end

	function automatic bit [KBITS-1:0] pick_key();
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// extremes of keys and ids, every op and the listed corner cases
	task automatic test_directed();
		send_beat(OP_WAKE, 31'd5, 5'd0);
		send_beat(OP_PEEK, 31'd5, 5'd0);
		send_beat(OP_REMOVE, 31'd0, 5'd7);
		send_beat(OP_BLOCK, '0, 5'd0);
		send_beat(OP_BLOCK, '1, 5'd31);
		send_beat(OP_BLOCK, '0, 5'd1);
		send_beat(OP_BLOCK, '0, 5'd0);
		send_beat(OP_PEEK, '0, 5'd31);
		send_beat(OP_PEEK, '1, 5'd0);
		send_beat(OP_BLOCK, 31'h2AAA_AAAA, 5'd21);
		send_beat(OP_BLOCK, 31'h5555_5555, 5'd10);
		send_beat(OP_REMOVE, '1, 5'd1);
		send_beat(OP_REMOVE, 31'd9, 5'd0);
		send_beat(OP_WAKE, '0, 5'd3);
		send_beat(OP_WAKE, '0, 5'd3);
		send_beat(OP_REMOVE, '0, 5'd31);
		send_beat(OP_REMOVE, '0, 5'd31);
		send_beat(OP_WAKE, 31'h2AAA_AAAA, 5'd0);
		send_beat(OP_WAKE, 31'h5555_5555, 5'd0);
		wait_drained();
	endtask

	// every descriptor in use: 32 distinct keys, one waiter each
	task automatic test_pool_full();
		for (int i = 0; i < NPROC; i++)
			send_beat(OP_BLOCK, 31'(1000 + i), 5'(i));
		for (int i = 0; i < NPROC; i++)
			send_beat(OP_PEEK, 31'(1000 + i), 5'd0);
		for (int i = 0; i < NPROC; i++)
			send_beat(OP_WAKE, 31'(1000 + i), 5'd0);
		wait_drained();
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (2) @(posedge clk);
		hold_req = 1'b0;
		for (int i = 0; i < 20; i++)
			send_beat(op_t'($urandom_range(0, 3)), pick_key(), 5'($urandom));
		wait_drained();
	endtask

	// random traffic, mostly on a small key set so queues grow deep
	task automatic test_random(int count);
		bit [KBITS-1:0] k;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			k = (r < 90) ? pick_key() : 31'($urandom);
			if (r < 45) send_beat(OP_BLOCK, k, 5'($urandom));
			else if (r < 65) send_beat(OP_WAKE, k, 5'($urandom));
			else if (r < 85) send_beat(OP_REMOVE, 31'($urandom), 5'($urandom));
			else send_beat(OP_PEEK, k, 5'($urandom));
			if (i % 300 == 299) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		sem_key = '0;
		proc_id = '0;
		rx_hold = 0;
		hold_req = 1'b0;
		rx_random = 1'b0;
		tx_gaps = 1'b0;
		mismatch_count = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		for (int i = 0; i < NPROC; i++) begin
			tbl_valid[i] = 1'b0;
			waiter_blocked[i] = 1'b0;
		end
		key_pool = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd2, 31'h4000_0000,
			31'h2AAA_AAAA, 31'h5555_5555, 31'd77};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_full();
		rx_random = 1'b1;
		tx_gaps = 1'b1;
		test_backpressure();
		test_random(900);
		tx_gaps = 1'b0;
		rx_random = 1'b0;
		test_random(400);
		rx_random = 1'b1;
		tx_gaps = 1'b1;
		test_random(400);

		rx_random = 1'b0;
		wait_drained();
		repeat (60) @(posedge clk);
		$display("covered %0d beats in, %0d results checked: all ops, key extremes,", beats_in,
			beats_out);
		$display("pool exhaustion, deep queues, long output hold-off and random gaps");
		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("PASS semaphore_wait_queue_table");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				pending_answers.size());
			$display("FAIL semaphore_wait_queue_table");
		end
		$finish;
	end

endmodule
